// ===== sv/virtual_compare_timer_mux_macros.svh =====
// Assertion helpers shared by the timer multiplexer RTL.
`ifndef VIRTUAL_COMPARE_TIMER_MUX_MACROS_SVH
`define VIRTUAL_COMPARE_TIMER_MUX_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define VCTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vctm: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define VCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vctm: next-cycle check failed");

`else

`define VCTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/vctm_pkg.sv =====
package vctm_pkg;

    // Timer arithmetic width and result field width
    localparam int TimerBits  = 16;
    localparam int NumSources = 3;
    localparam int OutBits    = 16;
    localparam int SrcBits    = 2;
    localparam int OpBits     = 3;

    // Distance reported when no timer is armed
    localparam logic [OutBits-1:0] NoneDist = '1;

    typedef logic [TimerBits-1:0] t_time;
    typedef logic [OutBits-1:0]   t_out16;

    typedef enum logic [OpBits-1:0] {
        OP_START_ONESHOT  = 3'd0,
        OP_CANCEL_ONESHOT = 3'd1,
        OP_SET_PERIOD     = 3'd2,
        OP_SET_OFFSET     = 3'd3,
        OP_CANCEL_COMPARE = 3'd4,
        OP_TICK           = 3'd5
    } t_op;

    typedef enum logic [SrcBits-1:0] {
        SRC_ONESHOT  = 2'd0,
        SRC_PERIODIC = 2'd1,
        SRC_OFFSET   = 2'd2
    } t_src;

    // Outcome of the nearest-timer selection
    typedef struct packed {
        logic               found;
        logic [SrcBits-1:0] src;
        t_time              sched;
        t_time              span;
    } t_pick;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [1:0]         pad;
        t_out16             oneshot_elapsed;
        t_out16             time_to_fire;
        t_out16             next_compare;
        logic               next_armed;
        logic [SrcBits-1:0] next_source;
        logic [SrcBits-1:0] fired_source;
        logic               fired;
    } t_result;

endpackage

// ===== sv/virtual_compare_timer_mux.sv =====
// Channel   Dir  Handshake              Payload
// s (cmd)   in   i_s_tvalid/o_s_tready  i_s_tuser = op, i_s_tdata = amount
// m (res)   out  o_m_tvalid/i_m_tready  o_m_tdata = fired .. oneshot_elapsed
//
// One item per cycle while the result side is not stalled: a command or tick is
// held in the input register, then the timer state updates and the result is
// registered at the same edge. The three-way compare and nearest-timer selection
// sit in a single stage, between the input register and the result register.
// Synchronous active-low reset clears all timer state and both valid flags.
// A stalled result holds the input register, which backs up into o_s_tready.
`include "virtual_compare_timer_mux_macros.svh"

module virtual_compare_timer_mux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] amount
    input  logic [2:0]  i_s_tuser,   // [2:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [0] fired, [2:1] fired_source, [4:3] next_source,
                                     // [5] next_armed, [21:6] next_compare,
                                     // [37:22] time_to_fire, [53:38] oneshot_elapsed,
                                     // [55:54] zero
);
    import vctm_pkg::*;

    // Input register
    logic                r_in_valid;
    logic [OpBits-1:0]   r_op;
    t_time               r_amt;

    // Timer state
    t_time                        r_counter,    n_counter;
    t_time [NumSources-1:0]       r_compare,    n_compare;
    logic [NumSources-1:0]        r_armed,      n_armed;
    t_time                        r_last_fire,  n_last_fire;
    t_time                        r_sched_time, n_sched_time;
    logic [SrcBits-1:0]           r_sched_src,  n_sched_src;
    t_time                        r_period,     n_period;
    t_time                        r_base,       n_base;
    t_time                        r_offset,     n_offset;
    t_time                        r_total,      n_total;

    // Result register
    logic                r_out_valid;
    t_result             r_res,        n_res;

    logic                w_advance;
    logic                w_fired;
    logic [SrcBits-1:0]  w_fsrc;
    logic                w_el_armed;
    t_time               w_elapsed;
    t_pick               w_pick;

    // Move the input item into the stage when the result slot is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op  <= i_s_tuser;
            r_amt <= TimerBits'(i_s_tdata[15:0]);
        end
    end

    // Apply the command or tick to the timer state
    always_comb begin
        n_counter   = r_counter;
        n_compare   = r_compare;
        n_armed     = r_armed;
        n_last_fire = r_last_fire;
        n_period    = r_period;
        n_base      = r_base;
        n_offset    = r_offset;
        n_total     = r_total;
        w_fired     = 1'b0;
        w_fsrc      = SRC_ONESHOT;
        unique case (r_op)
            OP_START_ONESHOT: begin
                n_total      = r_amt;
                n_compare[0] = r_compare[0] + r_amt;
                n_armed[0]   = 1'b1;
            end
            OP_CANCEL_ONESHOT: begin
                n_total      = '0;
                n_compare[0] = '0;
                n_armed[0]   = 1'b0;
            end
            OP_SET_PERIOD: begin
                n_period     = r_amt;
                n_base       = r_compare[1];
                n_compare[1] = r_compare[1] + r_amt;
                n_armed[1]   = 1'b1;
            end
            OP_SET_OFFSET: begin
                n_offset     = r_amt;
                n_compare[2] = r_base + r_amt;
                n_armed[2]   = 1'b1;
            end
            OP_CANCEL_COMPARE: begin
                n_armed[2] = 1'b0;
            end
            OP_TICK: begin
                n_counter = r_counter + 1'b1;
                if ((|r_armed) && n_counter == r_sched_time) begin
                    w_fired     = 1'b1;
                    w_fsrc      = r_sched_src;
                    n_last_fire = r_sched_time;
                    unique case (r_sched_src)
                        SRC_ONESHOT: begin
                            n_armed[0] = 1'b0;
                        end
                        SRC_PERIODIC: begin
                            n_base       = r_compare[1];
                            n_compare[1] = r_compare[1] + r_period;
                        end
                        default: begin
                            // rearm the offset from the pending overflow compare
                            n_compare[2] = r_compare[1] + r_offset;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    vctm_select u_select (
        .i_armed     (n_armed),
        .i_compare   (n_compare),
        .i_last_fire (n_last_fire),
        .i_prev_time (r_sched_time),
        .i_prev_src  (r_sched_src),
        .o_pick      (w_pick)
    );

    assign n_sched_time = w_pick.sched;
    assign n_sched_src  = w_pick.src;

    // Sample one-shot progress before a firing one-shot is disarmed
    assign w_el_armed = w_fired ? r_armed[0] : n_armed[0];
    assign w_elapsed  = w_el_armed ? (n_total - (n_compare[0] - n_counter)) : '0;

    // Assemble the result item
    always_comb begin
        n_res                 = '0;
        n_res.fired           = w_fired;
        n_res.fired_source    = w_fsrc;
        n_res.next_source     = w_pick.src;
        n_res.next_armed      = |n_armed;
        n_res.next_compare    = OutBits'(w_pick.sched);
        n_res.time_to_fire    = w_pick.found ? OutBits'(w_pick.span) : NoneDist;
        n_res.oneshot_elapsed = OutBits'(w_elapsed);
    end

    // Commit state on each advanced item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter    <= '0;
            r_compare    <= '0;
            r_armed      <= '0;
            r_last_fire  <= '0;
            r_sched_time <= '0;
            r_sched_src  <= '0;
            r_period     <= '0;
            r_base       <= '0;
            r_offset     <= '0;
            r_total      <= '0;
        end else if (w_advance) begin
            r_counter    <= n_counter;
            r_compare    <= n_compare;
            r_armed      <= n_armed;
            r_last_fire  <= n_last_fire;
            r_sched_time <= n_sched_time;
            r_sched_src  <= n_sched_src;
            r_period     <= n_period;
            r_base       <= n_base;
            r_offset     <= n_offset;
            r_total      <= n_total;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    // A result without a match names no source
    `VCTM_ASSERT_SAME(a_nofire_src, i_clk, i_rst_n, r_out_valid && !r_res.fired, r_res.fired_source == SRC_ONESHOT)
    // With nothing armed the distance reads all ones
    `VCTM_ASSERT_SAME(a_idle_dist, i_clk, i_rst_n, r_out_valid && !r_res.next_armed, r_res.time_to_fire == NoneDist)
    // Only a tick moves the counter
    `VCTM_ASSERT_NEXT(a_counter_hold, i_clk, i_rst_n, !(w_advance && r_op == OP_TICK), $stable(r_counter))
    // A one-shot match disarms the one-shot
    `VCTM_ASSERT_NEXT(a_oneshot_disarm, i_clk, i_rst_n, w_advance && w_fired && w_fsrc == SRC_ONESHOT, !r_armed[0])

endmodule

// ===== sv/vctm_select.sv =====
module vctm_select (
    input  logic [vctm_pkg::NumSources-1:0]                 i_armed,
    input  vctm_pkg::t_time [vctm_pkg::NumSources-1:0]      i_compare,
    input  vctm_pkg::t_time                                 i_last_fire,
    input  vctm_pkg::t_time                                 i_prev_time,
    input  logic [vctm_pkg::SrcBits-1:0]                    i_prev_src,
    output vctm_pkg::t_pick                                 o_pick
);
    import vctm_pkg::*;

    // Pick the armed timer nearest to the last fire time; ties go to the lower source
    always_comb begin
        t_time d;
        o_pick.found = 1'b0;
        o_pick.span  = '1;
        o_pick.sched = i_prev_time;
        o_pick.src   = i_prev_src;
        for (int i = 0; i < NumSources; i++) begin
            d = i_compare[i] - i_last_fire;
            if (i_armed[i] && (!o_pick.found || d < o_pick.span)) begin
                o_pick.found = 1'b1;
                o_pick.span  = d;
                o_pick.sched = i_compare[i];
                o_pick.src   = SrcBits'(i);
            end
        end
    end

endmodule

// ===== dv/tb_virtual_compare_timer_mux.sv =====
`timescale 1ns / 100ps

module tb_virtual_compare_timer_mux;
    import vctm_pkg::*;

    // Op codes that the block must ignore
    localparam logic [OpBits-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OpBits-1:0] OP_SPARE_7 = 3'd7;

    // Report with nothing armed and nothing ever scheduled
    localparam t_result IDLE_REPORT = '{2'b00, 16'h0000, NoneDist, 16'h0000, 1'b0,
                                        SRC_ONESHOT, SRC_ONESHOT, 1'b0};

    // One opening command, with its report written out where it is obvious
    typedef struct packed {
        logic [OpBits-1:0] op;
        t_time             amt;
        logic              typed;
        t_result           rep;
    } t_opening_row;

    localparam int OpeningRows = 26;
    localparam t_opening_row OPENING [OpeningRows] = '{
        '{OP_TICK,           16'h0000, 1'b1, IDLE_REPORT},
        '{OP_SPARE_6,        16'hffff, 1'b1, IDLE_REPORT},
        '{OP_SPARE_7,        16'h1234, 1'b1, IDLE_REPORT},
        '{OP_CANCEL_COMPARE, 16'h0000, 1'b1, IDLE_REPORT},
        '{OP_CANCEL_ONESHOT, 16'hffff, 1'b1, IDLE_REPORT},
        // offset compare fires with no periodic timer, rearms at zero distance
        '{OP_SET_OFFSET,     16'h0002, 1'b0, '0},
        '{OP_TICK,           16'hffff, 1'b0, '0},
        '{OP_CANCEL_COMPARE, 16'h0000, 1'b0, '0},
        // widest period, then a tie between overflow and offset compares
        '{OP_SET_PERIOD,     16'hffff, 1'b0, '0},
        '{OP_SET_OFFSET,     16'h0000, 1'b0, '0},
        '{OP_SET_OFFSET,     16'hffff, 1'b0, '0},
        '{OP_CANCEL_COMPARE, 16'h0000, 1'b0, '0},
        // one-shot fires and drops out
        '{OP_START_ONESHOT,  16'h0003, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        // zero delay lands on the last fire time, then a relative restart
        '{OP_START_ONESHOT,  16'h0000, 1'b0, '0},
        '{OP_START_ONESHOT,  16'h0002, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        // zero period, then periodic and offset matches back to back
        '{OP_SET_PERIOD,     16'h0000, 1'b0, '0},
        '{OP_SET_PERIOD,     16'h0008, 1'b0, '0},
        '{OP_SET_OFFSET,     16'h0009, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        '{OP_TICK,           16'h0000, 1'b0, '0},
        '{OP_START_ONESHOT,  16'hffff, 1'b0, '0},
        '{OP_CANCEL_ONESHOT, 16'h0000, 1'b0, '0}
    };

    localparam int RandomCmds = 880;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [15:0] amount
    logic [2:0]  i_s_tuser  = '0;   // [2:0] op
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;         // [0] fired, [2:1] fired_source, [4:3] next_source,
                                    // [5] next_armed, [21:6] next_compare,
                                    // [37:22] time_to_fire, [53:38] oneshot_elapsed

    // Timer state mirrored on the testbench side
    t_time tm_count;
    t_time tm_cmp [NumSources];
    bit    tm_armed [NumSources];
    t_time tm_last_fire;
    t_time tm_sched_time;
    t_src  tm_sched_src;
    t_time tm_period;
    t_time tm_base;
    t_time tm_offset;
    t_time tm_total;
    int    fire_tally [NumSources];

    t_result due_reports [$];
    int      fault_cnt   = 0;
    int      cmd_total   = 0;
    int      tick_total  = 0;
    int      checked_cnt = 0;
    bit      steady_flow = 1'b0;
    bit      send_calm   = 1'b0;

    virtual_compare_timer_mux u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Ticks of the one-shot elapsed so far, zero while it is idle
    function automatic t_time oneshot_progress();
        if (!tm_armed[SRC_ONESHOT]) begin
            return '0;
        end
        return tm_total - (tm_cmp[SRC_ONESHOT] - tm_count);
    endfunction

    // Apply one command to the mirrored timers and build the report it causes
    function automatic t_result apply_timer_cmd(input logic [OpBits-1:0] op, input t_time amt);
        t_result rep;
        t_time   best_span;
        t_time   span;
        t_time   elapsed;
        t_src    fsrc;
        bit      fire_now;
        bit      found;
        int      i;

        fsrc     = SRC_ONESHOT;
        fire_now = 1'b0;
        elapsed  = '0;
        case (op)
            OP_START_ONESHOT: begin
                tm_total = amt;
                tm_cmp[SRC_ONESHOT] = tm_cmp[SRC_ONESHOT] + amt;
                tm_armed[SRC_ONESHOT] = 1'b1;
            end
            OP_CANCEL_ONESHOT: begin
                tm_total = '0;
                tm_cmp[SRC_ONESHOT] = '0;
                tm_armed[SRC_ONESHOT] = 1'b0;
            end
            OP_SET_PERIOD: begin
                tm_period = amt;
                tm_base = tm_cmp[SRC_PERIODIC];
                tm_cmp[SRC_PERIODIC] = tm_cmp[SRC_PERIODIC] + amt;
                tm_armed[SRC_PERIODIC] = 1'b1;
            end
            OP_SET_OFFSET: begin
                tm_offset = amt;
                tm_cmp[SRC_OFFSET] = tm_base + amt;
                tm_armed[SRC_OFFSET] = 1'b1;
            end
            OP_CANCEL_COMPARE: begin
                tm_armed[SRC_OFFSET] = 1'b0;
            end
            OP_TICK: begin
                tm_count = tm_count + 1'b1;
                if ((tm_armed[0] || tm_armed[1] || tm_armed[2]) && tm_count == tm_sched_time) begin
                    fire_now = 1'b1;
                    fsrc = tm_sched_src;
                    tm_last_fire = tm_sched_time;
                    elapsed = oneshot_progress();
                    fire_tally[fsrc]++;
                    case (fsrc)
                        SRC_ONESHOT: tm_armed[SRC_ONESHOT] = 1'b0;
                        SRC_PERIODIC: begin
                            tm_base = tm_cmp[SRC_PERIODIC];
                            tm_cmp[SRC_PERIODIC] = tm_cmp[SRC_PERIODIC] + tm_period;
                        end
                        default: tm_cmp[SRC_OFFSET] = tm_cmp[SRC_PERIODIC] + tm_offset;
                    endcase
                end
            end
            default: ;
        endcase

        // Pick the armed timer nearest after the last fire time, first one on a tie
        found     = 1'b0;
        best_span = NoneDist;
        for (i = 0; i < NumSources; i++) begin
            if (tm_armed[i]) begin
                span = tm_cmp[i] - tm_last_fire;
                if (!found || span < best_span) begin
                    best_span = span;
                    found = 1'b1;
                    tm_sched_time = tm_cmp[i];
                    tm_sched_src = t_src'(i);
                end
            end
        end
        if (!fire_now) begin
            elapsed = oneshot_progress();
        end

        rep                 = '0;
        rep.fired           = fire_now;
        rep.fired_source    = fsrc;
        rep.next_source     = tm_sched_src;
        rep.next_armed      = tm_armed[0] || tm_armed[1] || tm_armed[2];
        rep.next_compare    = tm_sched_time;
        rep.time_to_fire    = best_span;
        rep.oneshot_elapsed = elapsed;
        return rep;
    endfunction

    // Present one command, hold it until the transfer, then queue its report
    task automatic send_cmd(input logic [OpBits-1:0] op, input t_time amt,
                            input bit typed, input t_result typed_rep);
        int      gap;
        t_result rep;

        if ($urandom_range(0, 31) == 0) begin
            send_calm = !send_calm;
        end
        gap = (send_calm || steady_flow) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= amt;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        rep = apply_timer_cmd(op, amt);
        due_reports.push_back(typed ? typed_rep : rep);
        cmd_total++;
        if (op == OP_TICK) begin
            tick_total++;
        end
    endtask

    // Place a source's target a few ticks past the current count
    task automatic arm_ahead(input t_src src, input int unsigned lead);
        t_time target;

        target = tm_count + t_time'(lead);
        case (src)
            SRC_ONESHOT:  send_cmd(OP_START_ONESHOT, target - tm_cmp[SRC_ONESHOT], 1'b0, '0);
            SRC_PERIODIC: send_cmd(OP_SET_PERIOD, target - tm_cmp[SRC_PERIODIC], 1'b0, '0);
            default:      send_cmd(OP_SET_OFFSET, target - tm_base, 1'b0, '0);
        endcase
    endtask

    // Accept results with random stalls and check each against the oldest report
    initial begin : result_sink
        int      gap;
        bit      calm;
        t_result got;
        t_result want;

        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                calm = !calm;
            end
            gap = (calm || steady_flow) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            got = t_result'(o_m_tdata);
            if (due_reports.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10) begin
                    $display("unexpected result after %0d checked: %h", checked_cnt, o_m_tdata);
                end
            end else begin
                want = due_reports.pop_front();
                if (got.fired           !== want.fired           ||
                    got.fired_source    !== want.fired_source    ||
                    got.next_source     !== want.next_source     ||
                    got.next_armed      !== want.next_armed      ||
                    got.next_compare    !== want.next_compare    ||
                    got.time_to_fire    !== want.time_to_fire    ||
                    got.oneshot_elapsed !== want.oneshot_elapsed) begin
                    fault_cnt++;
                    if (fault_cnt <= 10) begin
                        $display("result %0d mismatch: expected fired=%0b src=%0d next=%0d armed=%0b",
                                 checked_cnt, want.fired, want.fired_source, want.next_source,
                                 want.next_armed);
                        $display("    compare=%h dist=%h elapsed=%h, got fired=%0b src=%0d next=%0d",
                                 want.next_compare, want.time_to_fire, want.oneshot_elapsed,
                                 got.fired, got.fired_source, got.next_source);
                        $display("    armed=%0b compare=%h dist=%h elapsed=%h",
                                 got.next_armed, got.next_compare, got.time_to_fire,
                                 got.oneshot_elapsed);
                    end
                end
                checked_cnt++;
            end
        end
    end

    initial begin : stimulus
        int           row;
        int           rnd_cmds;
        int           seen;
        int           drain;
        int unsigned  roll;
        logic [OpBits-1:0] op;
        t_time        amt;
        bit           stuck;

        // Start the mirrored timers from the reset state
        tm_count      = '0;
        tm_last_fire  = '0;
        tm_sched_time = '0;
        tm_sched_src  = SRC_ONESHOT;
        tm_period     = '0;
        tm_base       = '0;
        tm_offset     = '0;
        tm_total      = '0;
        for (row = 0; row < NumSources; row++) begin
            tm_cmp[row]     = '0;
            tm_armed[row]   = 1'b0;
            fire_tally[row] = 0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the opening table
        for (row = 0; row < OpeningRows; row++) begin
            send_cmd(OPENING[row].op, OPENING[row].amt, OPENING[row].typed, OPENING[row].rep);
        end

        // Mostly near-future targets and ticks, with some noise and cancels
        rnd_cmds = 0;
        while (rnd_cmds < RandomCmds) begin
            stuck = (tm_armed[0] || tm_armed[1] || tm_armed[2]) &&
                    t_time'(tm_sched_time - tm_last_fire) <= t_time'(tm_count - tm_last_fire);
            roll = $urandom_range(0, 99);
            if (stuck && roll < 85) begin
                // move a target the count has already passed back ahead of it
                arm_ahead(tm_sched_src, $urandom_range(1, 12));
                rnd_cmds++;
            end else if (roll < 55) begin
                send_cmd(OP_TICK, t_time'($urandom_range(0, 65535)), 1'b0, '0);
                rnd_cmds++;
            end else if (roll < 80) begin
                arm_ahead(t_src'($urandom_range(0, 2)), $urandom_range(1, 24));
                rnd_cmds++;
            end else if (roll < 86) begin
                op = (roll[0]) ? OP_CANCEL_ONESHOT : OP_CANCEL_COMPARE;
                send_cmd(op, t_time'($urandom_range(0, 65535)), 1'b0, '0);
                rnd_cmds++;
            end else begin
                op = OpBits'($urandom_range(0, 7));
                case ($urandom_range(0, 3))
                    0:       amt = '0;
                    1:       amt = '1;
                    default: amt = t_time'($urandom_range(0, 65535));
                endcase
                send_cmd(op, amt, 1'b0, '0);
                if (op <= OP_TICK) begin
                    rnd_cmds++;
                end
            end
        end

        // Close on a periodic match with no idle cycles on either side
        steady_flow = 1'b1;
        send_cmd(OP_CANCEL_ONESHOT, '0, 1'b0, '0);
        send_cmd(OP_CANCEL_COMPARE, '0, 1'b0, '0);
        seen = fire_tally[SRC_PERIODIC];
        arm_ahead(SRC_PERIODIC, 1);
        while (fire_tally[SRC_PERIODIC] == seen) begin
            send_cmd(OP_TICK, '0, 1'b0, '0);
        end
        steady_flow = 1'b0;
        i_s_tvalid <= 1'b0;

        // Drain the outstanding reports, then give stray results a chance to show
        drain = 0;
        while (due_reports.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (due_reports.size() != 0) begin
            fault_cnt += due_reports.size();
            $display("%0d results never arrived", due_reports.size());
        end

        $display("%0d commands sent (%0d ticks), %0d results checked",
                 cmd_total, tick_total, checked_cnt);
        $display("matches seen: one-shot %0d, periodic %0d, offset %0d",
                 fire_tally[SRC_ONESHOT], fire_tally[SRC_PERIODIC], fire_tally[SRC_OFFSET]);
        if (fault_cnt == 0) begin
            $display("virtual_compare_timer_mux verification clean");
        end else begin
            $display("virtual_compare_timer_mux verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(4_000_000);
        $display("virtual_compare_timer_mux verification failed");
        $finish;
    end

endmodule

// ===== virtual_compare_timer_mux.f =====
+incdir+sv
sv/vctm_pkg.sv
sv/vctm_select.sv
sv/virtual_compare_timer_mux.sv
dv/tb_virtual_compare_timer_mux.sv
